// ----- rtl/core/xsb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the X-Trans superpixel binning block.
// Used by xsb_pos, xsb_acc and xtrans_superpixel_bin; depends on nothing.
package xsb_pkg;

  localparam int PIXEL_BITS      = 16;
  localparam int MAX_SUPER_WIDTH = 2048;
  localparam int IDX_W           = (MAX_SUPER_WIDTH > 1) ? $clog2(MAX_SUPER_WIDTH) : 1;

  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 14;
  localparam int CFG_W    = 14;
  localparam int SUM_W    = 21;
  localparam int SX_W     = 12;

  // Configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(6144);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(4096);

  // Position of one sample inside the frame, as the accumulator needs it
  typedef struct packed {
    logic             in_range;
    logic             frame_last;
    logic [1:0]       bcol;
    logic [1:0]       brow;
    logic [IDX_W-1:0] idx;
  } pos_info_t;

endpackage

// ----- rtl/core/xtrans_superpixel_bin.sv -----
`timescale 1ns / 1ps
// X-Trans 3x3 superpixel binning, top level.
// Depends on xsb_pkg, xsb_pos and xsb_acc.
//
// Usage:
//  - Input channel (in_valid / in_stall / pixel): raw samples in raster order.
//    A transaction completes on a rising edge with in_valid high and in_stall low.
//  - Output channel (out_valid / out_stall / super_value / frame_last): one
//    transaction per kept 3x3 block, value 5*(red+blue) + 2*(green). frame_last
//    marks the final block of the frame.
//  - Configuration (cfg_write / cfg_index / cfg_data): image_width at index 0,
//    image_height at index 1. Write only while the block is idle.
// Output: the sum of a block is registered in the output register once its last
//   sample (bottom-right) has been accepted and has left the accumulate stage.
// Throughput: one sample per cycle while the receiver does not stall; the
//   accumulate stage and the output register each take a new item as they hand
//   on the last, and the partial-sum RAM does one read and one write per cycle.
// Reset: positions, running sum and both pipeline valids clear; the registers
//   return to 6144 x 4096. The partial-sum RAM is not cleared; a frame must
//   start at block row 0 before its entries are read.
// Receiver stall: the output register holds its transaction; the input side
//   stalls only once a finished block is waiting behind it.
module xtrans_superpixel_bin (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [xsb_pkg::PIXEL_BITS-1:0] pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [xsb_pkg::SUM_W-1:0]      super_value,
  output logic                           frame_last,
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [xsb_pkg::CFG_W-1:0]      cfg_data
);

  logic [xsb_pkg::WIDTH_W-1:0]  image_width;
  logic [xsb_pkg::HEIGHT_W-1:0] image_height;
  logic                         take;
  xsb_pkg::pos_info_t           info;

  // Configuration registers: keep the low bits of the written data
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= xsb_pkg::WIDTH_RESET;
      image_height <= xsb_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        xsb_pkg::REG_IMAGE_WIDTH:  image_width  <= xsb_pkg::WIDTH_W'(cfg_data);
        xsb_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept an input transaction
  assign take = in_valid && !in_stall;

  // Track raster position; advance on every accepted sample, kept or dropped
  xsb_pos u_pos (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .image_width  (image_width),
    .image_height (image_height),
    .info         (info)
  );

  // Weight, accumulate across block rows, and hold the result for the receiver
  xsb_acc u_acc (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .pixel       (pixel),
    .info        (info),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .super_value (super_value),
    .frame_last  (frame_last)
  );

endmodule

// ----- rtl/core/xsb_pos.sv -----
`timescale 1ns / 1ps
// Raster position tracker: column/row counters with block phase and block index.
// Depends on xsb_pkg.
module xsb_pos (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [xsb_pkg::WIDTH_W-1:0]  image_width,
  input  logic [xsb_pkg::HEIGHT_W-1:0] image_height,
  output xsb_pkg::pos_info_t           info
);

  logic [xsb_pkg::WIDTH_W-1:0]  col;
  logic [xsb_pkg::WIDTH_W-1:0]  col_next;
  logic [1:0]                   bcol;
  logic [1:0]                   bcol_next;
  logic [xsb_pkg::SX_W-1:0]     sx;
  logic [xsb_pkg::SX_W-1:0]     sx_next;
  logic [xsb_pkg::HEIGHT_W-1:0] row;
  logic [xsb_pkg::HEIGHT_W-1:0] row_next;
  logic [1:0]                   brow;
  logic [1:0]                   brow_next;

  logic [xsb_pkg::WIDTH_W+1:0]  col_blk_end;
  logic [xsb_pkg::HEIGHT_W+1:0] row_blk_end;
  logic                         col_ok;
  logic                         row_ok;
  logic                         col_wrap;
  logic                         row_wrap;

  // Last column/row of the current 3x3 block; a block is kept when it fits
  assign col_blk_end = (xsb_pkg::WIDTH_W+2)'(col) - (xsb_pkg::WIDTH_W+2)'(bcol)
                       + (xsb_pkg::WIDTH_W+2)'(2);
  assign row_blk_end = (xsb_pkg::HEIGHT_W+2)'(row) - (xsb_pkg::HEIGHT_W+2)'(brow)
                       + (xsb_pkg::HEIGHT_W+2)'(2);
  assign col_ok = col_blk_end < (xsb_pkg::WIDTH_W+2)'(image_width);
  assign row_ok = row_blk_end < (xsb_pkg::HEIGHT_W+2)'(image_height);

  always_comb begin
    info.in_range   = col_ok && row_ok;
    info.frame_last = (col_blk_end + (xsb_pkg::WIDTH_W+2)'(3)
                       >= (xsb_pkg::WIDTH_W+2)'(image_width))
                   && (row_blk_end + (xsb_pkg::HEIGHT_W+2)'(3)
                       >= (xsb_pkg::HEIGHT_W+2)'(image_height));
    info.bcol       = bcol;
    info.brow       = brow;
    info.idx        = xsb_pkg::IDX_W'(sx);
  end

  assign col_wrap = (xsb_pkg::WIDTH_W+1)'(col) + (xsb_pkg::WIDTH_W+1)'(1)
                    >= (xsb_pkg::WIDTH_W+1)'(image_width);
  assign row_wrap = (xsb_pkg::HEIGHT_W+1)'(row) + (xsb_pkg::HEIGHT_W+1)'(1)
                    >= (xsb_pkg::HEIGHT_W+1)'(image_height);

  always_comb begin
    col_next  = col;
    bcol_next = bcol;
    sx_next   = sx;
    row_next  = row;
    brow_next = brow;
    if (col_wrap) begin
      col_next  = '0;
      bcol_next = '0;
      sx_next   = '0;
      if (row_wrap) begin
        row_next  = '0;
        brow_next = '0;
      end else begin
        row_next  = row + xsb_pkg::HEIGHT_W'(1);
        brow_next = (brow == 2'd2) ? 2'd0 : brow + 2'd1;
      end
    end else begin
      col_next = col + xsb_pkg::WIDTH_W'(1);
      if (bcol == 2'd2) begin
        bcol_next = 2'd0;
        sx_next   = sx + xsb_pkg::SX_W'(1);
      end else begin
        bcol_next = bcol + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      bcol <= '0;
      sx   <= '0;
      row  <= '0;
      brow <= '0;
    end else if (take) begin
      col  <= col_next;
      bcol <= bcol_next;
      sx   <= sx_next;
      row  <= row_next;
      brow <= brow_next;
    end
  end

endmodule

// ----- rtl/core/xsb_acc.sv -----
`timescale 1ns / 1ps
// Accumulate stage: weighted block-row sums, per-column partial-sum memory and
// the output register with its handshake. Depends on xsb_pkg.
module xsb_acc (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic [xsb_pkg::PIXEL_BITS-1:0] pixel,
  input  xsb_pkg::pos_info_t             info,
  output logic                           in_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [xsb_pkg::SUM_W-1:0]      super_value,
  output logic                           frame_last
);

  logic [xsb_pkg::SUM_W-1:0]      mem [xsb_pkg::MAX_SUPER_WIDTH];
  logic [xsb_pkg::SUM_W-1:0]      rd_data;

  logic                           s1_valid;
  logic [xsb_pkg::PIXEL_BITS-1:0] s1_pixel;
  xsb_pkg::pos_info_t             s1_info;
  logic [xsb_pkg::SUM_W-1:0]      cur_sum;

  logic                           s1_emit;
  logic                           s1_go;
  logic                           s1_wr;
  logic                           out_free;
  logic                           green;
  logic [xsb_pkg::SUM_W-1:0]      px_ext;
  logic [xsb_pkg::SUM_W-1:0]      wpx;
  logic [xsb_pkg::SUM_W-1:0]      blk_sum;
  logic [xsb_pkg::SUM_W-1:0]      total;

  assign s1_emit  = s1_valid && s1_info.in_range && (s1_info.bcol == 2'd2)
                    && (s1_info.brow == 2'd2);
  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && (!s1_emit || out_free);
  assign in_stall = s1_valid && !s1_go;
  assign s1_wr    = s1_go && s1_info.in_range && (s1_info.bcol == 2'd2)
                    && (s1_info.brow != 2'd2);

  // Green sits at columns 0,1 of block rows 0,1 and column 2 of block row 2
  assign green   = (s1_info.brow < 2'd2) ? (s1_info.bcol < 2'd2) : (s1_info.bcol == 2'd2);
  assign px_ext  = xsb_pkg::SUM_W'(s1_pixel);
  assign wpx     = green ? (px_ext << 1) : ((px_ext << 2) + px_ext);
  assign blk_sum = ((s1_info.bcol == 2'd0) ? '0 : cur_sum) + wpx;
  assign total   = rd_data + blk_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pixel <= pixel;
      s1_info  <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_sum <= '0;
    end else if (s1_go && s1_info.in_range) begin
      cur_sum <= blk_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      mem[s1_info.idx] <= (s1_info.brow == 2'd0) ? blk_sum : total;
    end
    if (take) begin
      rd_data <= mem[info.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      super_value <= total;
      frame_last  <= s1_info.frame_last;
    end
  end

  // Back-pressure only ever comes from a full, stalled output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // A finished block always lands in the output register
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_emit) |=> out_valid)
    else $error("emitted block did not reach the output register");

  // A sample that needs a partial sum never reads an entry being written
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (take && s1_wr && info.in_range && (info.bcol == 2'd2) && (info.brow != 2'd0))
      |-> (info.idx != s1_info.idx))
    else $error("partial-sum read collides with write");

  // Pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!s1_valid && !out_valid))
    else $error("pipeline not empty after reset");

endmodule
